FILE: hw/rtl/sbpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbpd_pkg
// Shared types and constants for the start-byte deframer: beat layouts,
// register indexes, per-channel state widths and queue sizing.
// ----------------------------------------------------------------------------
package sbpd_pkg;

  localparam int NUM_CHANNELS = 2;

  localparam int CH_W    = 1;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CTRL_CH0 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_CH1 = 1'd1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [BYTE_W-1:0] rx_byte;
  } sbpd_in_t;

  typedef struct packed {
    logic [CH_W-1:0]   out_channel;
    logic [BYTE_W-1:0] payload_byte;
    logic              is_last;
    logic              is_empty;
    logic [BYTE_W-1:0] frame_length;
  } sbpd_out_t;

  typedef struct packed {
    logic full;
    logic has_item;
  } sbpd_q_stat_t;

endpackage : sbpd_pkg
`default_nettype wire

FILE: hw/rtl/sbpd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbpd_front
// Accepts received bytes, tracks per-channel sync/position state and builds
// the payload beat, if any, for the queue.
// ----------------------------------------------------------------------------
module sbpd_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire sbpd_pkg::sbpd_in_t            in_data,
  input  wire logic                          cfg_we,
  input  wire logic [sbpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sbpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                          q_full,
  output logic                               q_push,
  output sbpd_pkg::sbpd_out_t                q_wdata
);
  import sbpd_pkg::*;

  logic [BYTE_W-1:0] ctrl0_r, ctrl1_r;
  logic              lock_r [NUM_CHANNELS];
  logic [POS_W-1:0]  pos_r  [NUM_CHANNELS];
  logic [BYTE_W-1:0] len_r  [NUM_CHANNELS];

  logic              accept, ch_ok, upd;
  logic [CH_W-1:0]   ch;
  logic [BYTE_W-1:0] b, ctrl, len;
  logic [POS_W-1:0]  p, len_ext;
  logic              lk, last;
  logic              lock_nxt;
  logic [POS_W-1:0]  pos_nxt;
  logic [BYTE_W-1:0] len_nxt;
  logic              emit;
  sbpd_out_t         res;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign ch       = in_data.channel;
  assign b        = in_data.rx_byte;
  assign ch_ok    = (32'(ch) < NUM_CHANNELS);
  assign upd      = accept && ch_ok;

  assign ctrl    = (ch == CH_W'(0)) ? ctrl0_r : ctrl1_r;
  assign p       = pos_r[ch];
  assign len     = len_r[ch];
  assign lk      = lock_r[ch];
  assign len_ext = POS_W'(len);
  assign last    = (p - POS_W'(1)) >= len_ext;

  always_comb begin
    lock_nxt = lk;
    pos_nxt  = p;
    len_nxt  = len;
    emit     = 1'b0;
    res.out_channel  = ch;
    res.payload_byte = b;
    res.is_last      = 1'b0;
    res.is_empty     = 1'b0;
    res.frame_length = len;
    priority if (p == POS_W'(0)) begin
      if (b == ctrl) begin
        pos_nxt = POS_W'(1);
      end else begin
        lock_nxt = 1'b0;
        pos_nxt  = POS_W'(0);
      end
    end else if (p == POS_W'(1)) begin
      len_nxt = b;
      pos_nxt = POS_W'(2);
      if (lk && b == BYTE_W'(0)) begin
        pos_nxt          = POS_W'(0);
        emit             = 1'b1;
        res.payload_byte = BYTE_W'(0);
        res.is_last      = 1'b1;
        res.is_empty     = 1'b1;
        res.frame_length = BYTE_W'(0);
      end
    end else if (lk) begin
      emit        = 1'b1;
      res.is_last = last;
      pos_nxt     = last ? POS_W'(0) : p + POS_W'(1);
    end else begin
      if (p < len_ext + POS_W'(2)) begin
        pos_nxt = p + POS_W'(1);
      end else if (b == ctrl) begin
        lock_nxt = 1'b1;
        pos_nxt  = POS_W'(1);
      end else begin
        pos_nxt = POS_W'(0);
      end
    end
  end

  assign q_push  = upd && emit;
  assign q_wdata = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl0_r <= '0;
      ctrl1_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CTRL_CH0: ctrl0_r <= cfg_wdata;
        REG_CTRL_CH1: ctrl1_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (!rst_n) begin
        lock_r[c] <= 1'b0;
        pos_r[c]  <= '0;
        len_r[c]  <= '0;
      end else if (upd && 32'(ch) == c) begin
        lock_r[c] <= lock_nxt;
        pos_r[c]  <= pos_nxt;
        len_r[c]  <= len_nxt;
      end
    end
  end

endmodule : sbpd_front
`default_nettype wire

FILE: hw/rtl/sbpd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbpd_queue
// Short FIFO of result beats between the front and the back.
// ----------------------------------------------------------------------------
module sbpd_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire sbpd_pkg::sbpd_out_t   wdata,
  input  wire logic                  pop,
  output sbpd_pkg::sbpd_out_t        rdata,
  output sbpd_pkg::sbpd_q_stat_t     stat
);
  import sbpd_pkg::*;

  sbpd_out_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] v);
    return (32'(v) == QDEPTH - 1) ? '0 : v + QPTR_W'(1);
  endfunction

  assign rdata         = mem[rd_ptr_r];
  assign stat.full     = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.has_item = (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      cnt_r <= cnt_nxt;
    end
  end

endmodule : sbpd_queue
`default_nettype wire

FILE: hw/rtl/sbpd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbpd_back
// Output register: pulls result beats from the queue and holds them until
// the receiver takes them.
// ----------------------------------------------------------------------------
module sbpd_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sbpd_pkg::sbpd_q_stat_t q_stat,
  input  wire sbpd_pkg::sbpd_out_t   q_rdata,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output sbpd_pkg::sbpd_out_t        out_data
);
  import sbpd_pkg::*;

  logic      out_valid_r;
  sbpd_out_t out_data_r;
  logic      load;

  assign load      = !out_valid_r || !out_stall;
  assign q_pop     = q_stat.has_item && load;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= q_stat.has_item;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= q_rdata;
    end
  end

endmodule : sbpd_back
`default_nettype wire

FILE: hw/rtl/sync_byte_packet_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_byte_packet_deframer
// Two-channel deframer for control-byte / length-byte / payload frames with
// sync hunting and lock; one beat out per locked payload byte or empty frame.
// ----------------------------------------------------------------------------
//  port group | dir | handshake          | beat
//  in_*       | in  | in_valid/in_stall  | sbpd_in_t  (channel, rx_byte)
//  out_*      | out | out_valid/out_stall| sbpd_out_t (channel, byte, last, ...)
//  cfg_*      | in  | cfg_we             | cfg_index, cfg_wdata
//
//  One byte per cycle while in_stall is low; per-channel front state is
//  registered; a result reaches out_valid via the queue and output register.
//  A two-beat queue feeds the output register; in_stall rises when it fills.
//  Synchronous reset clears sync state and control bytes; no clearing pass.
// ----------------------------------------------------------------------------
module sync_byte_packet_deframer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire sbpd_pkg::sbpd_in_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output sbpd_pkg::sbpd_out_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [sbpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sbpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sbpd_pkg::*;

  sbpd_q_stat_t q_stat;
  sbpd_out_t    q_wdata, q_rdata;
  logic         q_push, q_pop;

  sbpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_stat.full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  sbpd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  sbpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule : sync_byte_packet_deframer
`default_nettype wire

FILE: hw/rtl/sbpd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbpd_checker
// Port-level checks on the deframer result beats, bound to the top level.
// ----------------------------------------------------------------------------
module sbpd_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire sbpd_pkg::sbpd_out_t             out_data
);
  import sbpd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat presented right after reset");

  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      out_data.is_last && out_data.payload_byte == '0 && out_data.frame_length == '0)
    else $error("empty frame beat malformed");

  a_mid_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_last |->
      !out_data.is_empty && out_data.frame_length != 8'd0 && out_data.frame_length != 8'd1)
    else $error("non-final beat with frame too short");

endmodule : sbpd_checker

bind sync_byte_packet_deframer sbpd_checker u_sbpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

FILE: test/tb_sync_byte_packet_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_byte_packet_deframer
// Self-checking bench for the two-channel deframer. A clocked driver presents
// byte beats from a pending queue and a clocked monitor predicts each
// accepted byte's result from its own copy of the per-channel sync state,
// then checks every output beat against the oldest prediction. Stimulus is a
// short directed run, then phases of mostly well-formed interleaved frames
// with noise and broken frames, each under new control bytes.
// ----------------------------------------------------------------------------
module tb_sync_byte_packet_deframer;
  import sbpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int SETTLE_CYCLES  = 8;
  localparam int NUM_PHASES     = 5;
  localparam int PHASE_BEATS    = 360;

  typedef enum logic {ITEM_BEAT, ITEM_HOLD} item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    sbpd_in_t   beat;
  } tx_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  sbpd_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sbpd_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_CTRL_CH0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sync_byte_packet_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  tx_item_t  tx_items [$];
  sbpd_out_t due_beats [$];

  // deframer state as seen by the predictor
  logic              chan_locked [NUM_CHANNELS];
  logic [POS_W-1:0]  frame_pos [NUM_CHANNELS];
  logic [BYTE_W-1:0] frame_len [NUM_CHANNELS];
  logic [BYTE_W-1:0] marker    [NUM_CHANNELS];

  logic [BYTE_W-1:0] gen_marker [NUM_CHANNELS];
  logic [BYTE_W-1:0] lane0 [$];
  logic [BYTE_W-1:0] lane1 [$];

  bit in_taken = 1'b0;
  bit calm = 1'b0;
  int in_gap = 0;
  int stall_gap = 0;
  int fails = 0;
  int idle_cycles = 0;

  task automatic deframe_beat(input sbpd_in_t b);
    logic [CH_W-1:0]   ch;
    logic [BYTE_W-1:0] ctrl;
    logic [POS_W-1:0]  p;
    logic [BYTE_W-1:0] len;
    logic              last;
    sbpd_out_t         r;
    ch = b.channel;
    if (32'(ch) >= NUM_CHANNELS) return;
    ctrl = marker[ch];
    p = frame_pos[ch];
    len = frame_len[ch];
    r = '0;
    r.out_channel = b.channel;
    if (p == 0) begin
      if (b.rx_byte == ctrl) begin
        frame_pos[ch] = 1;
      end else begin
        chan_locked[ch] = 1'b0;
        frame_pos[ch] = 0;
      end
    end else if (p == 1) begin
      frame_len[ch] = b.rx_byte;
      frame_pos[ch] = 2;
      if (chan_locked[ch] && b.rx_byte == 0) begin
        frame_pos[ch] = 0;
        r.is_last = 1'b1;
        r.is_empty = 1'b1;
        due_beats.push_back(r);
      end
    end else if (chan_locked[ch]) begin
      last = ((p - 9'd1) >= {1'b0, len});
      r.payload_byte = b.rx_byte;
      r.is_last = last;
      r.frame_length = len;
      due_beats.push_back(r);
      frame_pos[ch] = last ? '0 : p + 9'd1;
    end else if ({1'b0, p} < ({2'b0, len} + 10'd2)) begin
      frame_pos[ch] = p + 9'd1;
    end else if (b.rx_byte == ctrl) begin
      chan_locked[ch] = 1'b1;
      frame_pos[ch] = 1;
    end else begin
      frame_pos[ch] = 0;
    end
  endtask

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken = 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        chan_locked[c] = 1'b0;
        frame_pos[c] = '0;
        frame_len[c] = '0;
        marker[c] = '0;
      end
    end else begin
      sbpd_out_t want;
      in_taken = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (due_beats.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected beat: ch=%0d byte=%h last=%b empty=%b len=%0d",
                     out_data.out_channel, out_data.payload_byte, out_data.is_last,
                     out_data.is_empty, out_data.frame_length);
        end else begin
          want = due_beats.pop_front();
          if (out_data !== want) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp ch=%0d byte=%h last=%b empty=%b len=%0d,",
                       want.out_channel, want.payload_byte, want.is_last,
                       want.is_empty, want.frame_length,
                       " got ch=%0d byte=%h last=%b empty=%b len=%0d",
                       out_data.out_channel, out_data.payload_byte, out_data.is_last,
                       out_data.is_empty, out_data.frame_length);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_CTRL_CH0) marker[0] = cfg_wdata;
        else if (cfg_index == REG_CTRL_CH1) marker[1] = cfg_wdata;
      end
      if (in_taken) deframe_beat(in_data);
      if (in_taken || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // driver: input beats and output back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else if (tx_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (tx_items[0].kind == ITEM_HOLD) begin
          if (due_beats.size() == 0) void'(tx_items.pop_front());
          in_valid <= 1'b0;
        end else begin
          in_data <= tx_items[0].beat;
          void'(tx_items.pop_front());
          in_valid <= 1'b1;
        end
      end
      if (calm) begin
        out_stall <= 1'b0;
      end else if (stall_gap > 0) begin
        stall_gap--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_gap = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(input logic ch, input logic [BYTE_W-1:0] b);
    tx_item_t t;
    t.kind = ITEM_BEAT;
    t.beat.channel = ch;
    t.beat.rx_byte = b;
    tx_items.push_back(t);
  endtask

  task automatic lane_push(input logic ch, input logic [BYTE_W-1:0] b);
    if (ch) lane1.push_back(b);
    else lane0.push_back(b);
  endtask

  task automatic add_frame(input logic ch);
    logic [BYTE_W-1:0] ctrl;
    int unsigned       kind;
    int unsigned       len;
    int unsigned       sent;
    ctrl = gen_marker[ch];
    kind = $urandom_range(0, 99);
    if (kind >= 80 && kind < 88) begin
      lane_push(ch, BYTE_W'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 199) == 0) len = $urandom_range(128, 255);
    else if ($urandom_range(0, 9) == 0) len = 0;
    else len = $urandom_range(1, 8);
    sent = len;
    if (kind >= 88 && kind < 94 && len > 0) sent = $urandom_range(0, len - 1);
    if (kind >= 94) lane_push(ch, ctrl ^ BYTE_W'($urandom_range(1, 255)));
    else lane_push(ch, ctrl);
    lane_push(ch, BYTE_W'(len));
    for (int i = 0; i < sent; i++)
      lane_push(ch, ($urandom_range(0, 9) == 0) ? ctrl : BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic build_phase(input bit with_hold);
    tx_item_t hold;
    int       n;
    logic     ch;
    hold = '0;
    hold.kind = ITEM_HOLD;
    while (lane0.size() + lane1.size() < PHASE_BEATS) add_frame(1'($urandom_range(0, 1)));
    n = 0;
    while (lane0.size() + lane1.size() > 0) begin
      if (lane0.size() == 0) ch = 1'b1;
      else if (lane1.size() == 0) ch = 1'b0;
      else ch = 1'($urandom_range(0, 1));
      send(ch, ch ? lane1.pop_front() : lane0.pop_front());
      n++;
      if (with_hold && n == PHASE_BEATS / 2) tx_items.push_back(hold);
    end
  endtask

  task automatic settle();
    do @(posedge clk);
    while (tx_items.size() != 0 || in_valid || due_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  logic [BYTE_W-1:0] phase_ch0 [NUM_PHASES];
  logic [BYTE_W-1:0] phase_ch1 [NUM_PHASES];

  initial begin
    phase_ch0[0] = 8'hFF; phase_ch1[0] = 8'h00;
    phase_ch0[1] = 8'h00; phase_ch1[1] = 8'hFF;
    phase_ch0[2] = BYTE_W'($urandom_range(0, 255));
    phase_ch1[2] = BYTE_W'($urandom_range(0, 255));
    phase_ch0[3] = 8'h80; phase_ch1[3] = 8'h7F;
    phase_ch0[4] = BYTE_W'($urandom_range(0, 255));
    phase_ch1[4] = BYTE_W'($urandom_range(0, 255));
    gen_marker[0] = '0;
    gen_marker[1] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset control bytes (zero on both channels)
    send(0, 8'h00); send(0, 8'h03);                   // hunt: skip 3
    send(0, 8'hFF); send(0, 8'h00); send(0, 8'h80);
    send(0, 8'h00);                                    // check byte -> lock
    send(0, 8'h00);                                    // empty frame
    send(0, 8'h00); send(0, 8'h02); send(0, 8'hFF); send(0, 8'h01);
    send(0, 8'h7E);                                    // lost lock
    send(1, 8'h00); send(1, 8'h00); send(1, 8'h00);   // zero skip, lock
    send(1, 8'h01); send(1, 8'hAB);
    send(1, 8'h7E);                                    // lost lock
    send(1, 8'h00); send(1, 8'h01); send(1, 8'h55);
    send(1, 8'h33);                                    // failed resync
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(REG_CTRL_CH0, phase_ch0[ph]);
      write_reg(REG_CTRL_CH1, phase_ch1[ph]);
      gen_marker[0] = phase_ch0[ph];
      gen_marker[1] = phase_ch1[ph];
      if (ph == NUM_PHASES - 1) calm = 1'b1;
      build_phase(ph == 1 || ph == 3);
      settle();
    end

    repeat (20) @(posedge clk);
    if (fails == 0 && due_beats.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
